// ----- sv/ps2_keyboard_controller_defines.svh -----
// ============================================================================
// Keyboard controller assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ============================================================================
`ifndef PS2_KEYBOARD_CONTROLLER_DEFINES_SVH
`define PS2_KEYBOARD_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define KBC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define KBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define KBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KBC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define KBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define KBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/ps2kbc_pkg.sv -----
// ============================================================================
// Keyboard controller package
// Operation codes, command bytes, status bits and scan code queue sizing.
// ============================================================================
package ps2kbc_pkg;

    // Scan code queue sizing.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request operations.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;
    localparam logic [1:0] OP_PUSH  = 2'd3;

    // Port select values.
    localparam logic PORT_DATA   = 1'b0;
    localparam logic PORT_STATUS = 1'b1;

    // Result codes.
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_NO_DATA = 2'd1;
    localparam logic [1:0] RES_DROPPED = 2'd2;

    // Pending two-byte command codes.
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_CMDBYTE = 2'd1;
    localparam logic [1:0] PEND_OUTPORT = 2'd2;

    // Status register bit positions.
    localparam int ST_OBF = 0;
    localparam int ST_SYS = 2;
    localparam int ST_CMD = 3;
    localparam int ST_INH = 4;

    // Controller commands.
    localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
    localparam logic [7:0] CMD_IF_TEST     = 8'hAB;
    localparam logic [7:0] CMD_READ_CB     = 8'h20;
    localparam logic [7:0] CMD_WRITE_CB    = 8'h60;
    localparam logic [7:0] CMD_READ_OP     = 8'hD0;
    localparam logic [7:0] CMD_WRITE_OP    = 8'hD1;
    localparam logic [7:0] CMD_DISABLE_KBD = 8'hAD;
    localparam logic [7:0] CMD_ENABLE_KBD  = 8'hAE;

    // Response bytes and reset values.
    localparam logic [7:0] SELF_TEST_OK = 8'h55;
    localparam logic [7:0] IF_TEST_OK   = 8'h00;
    localparam logic [7:0] DATA_ACK     = 8'hFA;
    localparam logic [7:0] STATUS_RST   = 8'h04;
    localparam logic [7:0] CMDBYTE_RST  = 8'h01;
    localparam logic [7:0] OUTPORT_RST  = 8'h02;

    // Bit of the output port that drives the A20 gate.
    localparam int A20_BIT = 1;

    // One captured request.
    typedef struct packed {
        logic [1:0] opcode;
        logic       port_select;
        logic [7:0] write_byte;
        logic [7:0] scan_code;
    } req_t;

    // One result.
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raised;
        logic [1:0] result_code;
        logic       a20_gate;
    } rsp_t;

endpackage

// ----- sv/ps2_keyboard_controller.sv -----
// ============================================================================
// Keyboard controller
// Data and command/status ports, controller command set and scan code queue.
// ============================================================================
// Every request (port read, port write, interrupt poll or scan code push)
// produces exactly one result. The block takes one request per cycle when the
// result side keeps up: a request is captured in an input register, and from
// there all of its work (status and command decode, register updates and the
// queue push or pop) runs through one level of logic into the result register,
// where the result is held until it is taken. A stalled result holds the
// pipeline; the input register still takes one more request while the result
// waits. The scan code queue is a small register file of sixteen entries read
// at the head pointer; it needs no clearing after reset, and the block accepts
// requests as soon as reset is released.
`include "ps2_keyboard_controller_defines.svh"

module ps2_keyboard_controller
    import ps2kbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Request channel.
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] opcode,
    input  logic       port_select,
    input  logic [7:0] write_byte,
    input  logic [7:0] scan_code,
    // Result channel.
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] read_data,
    output logic       irq_raised,
    output logic [1:0] result_code,
    output logic       a20_gate
);

    // ------------------------------------------------------------------
    // Pipeline control.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_req_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic req_accept;
    logic s1_advance;

    // The captured request moves on when the result register is empty or
    // its current result is being taken in this cycle.
    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    logic [7:0]       status_reg;
    logic [7:0]       status_next;
    logic [7:0]       output_byte_reg;
    logic [7:0]       output_byte_next;
    logic [1:0]       pending_reg;
    logic [1:0]       pending_next;
    logic [7:0]       command_byte_reg;
    logic [7:0]       command_byte_next;
    logic [7:0]       output_port_reg;
    logic [7:0]       output_port_next;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       fifo_reg [QUEUE_DEPTH];
    logic             fifo_write;
    logic             fifo_full;
    logic             fifo_empty;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    assign fifo_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign head_inc   = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    // ------------------------------------------------------------------
    // Request processing: one pass from the input register to the result.
    // ------------------------------------------------------------------
    always_comb
    begin
        status_next       = status_reg;
        output_byte_next  = output_byte_reg;
        pending_next      = pending_reg;
        command_byte_next = command_byte_reg;
        output_port_next  = output_port_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        fifo_write        = 1'b0;
        rsp_next          = '0;

        unique case (s1_req_reg.opcode)
            OP_READ:
            begin
                if (s1_req_reg.port_select == PORT_STATUS)
                begin
                    rsp_next.read_data = status_reg;
                end
                else
                begin
                    // Reading the data port empties the output buffer.
                    rsp_next.read_data  = output_byte_reg;
                    status_next[ST_OBF] = 1'b0;
                end
            end
            OP_WRITE:
            begin
                if (s1_req_reg.port_select == PORT_STATUS)
                begin
                    status_next[ST_CMD] = 1'b1;
                    unique case (s1_req_reg.write_byte)
                        CMD_SELF_TEST:
                        begin
                            output_byte_next    = SELF_TEST_OK;
                            status_next[ST_OBF] = 1'b1;
                        end
                        CMD_IF_TEST:
                        begin
                            output_byte_next    = IF_TEST_OK;
                            status_next[ST_OBF] = 1'b1;
                        end
                        CMD_READ_CB:
                        begin
                            output_byte_next    = command_byte_reg;
                            status_next[ST_OBF] = 1'b1;
                        end
                        CMD_READ_OP:
                        begin
                            output_byte_next    = output_port_reg;
                            status_next[ST_OBF] = 1'b1;
                        end
                        CMD_WRITE_CB:    pending_next = PEND_CMDBYTE;
                        CMD_WRITE_OP:    pending_next = PEND_OUTPORT;
                        CMD_DISABLE_KBD: status_next[ST_INH] = 1'b1;
                        CMD_ENABLE_KBD:  status_next[ST_INH] = 1'b0;
                        default:
                        begin
                            // Unknown commands only mark the command port as written.
                        end
                    endcase
                end
                else
                begin
                    status_next[ST_CMD] = 1'b0;
                    pending_next        = PEND_NONE;
                    priority if (pending_reg == PEND_CMDBYTE)
                    begin
                        command_byte_next = s1_req_reg.write_byte;
                    end
                    else if (pending_reg == PEND_OUTPORT)
                    begin
                        output_port_next = s1_req_reg.write_byte;
                    end
                    else
                    begin
                        // Plain data byte: acknowledge it.
                        output_byte_next    = DATA_ACK;
                        status_next[ST_OBF] = 1'b1;
                    end
                end
            end
            OP_POLL:
            begin
                if (status_reg[ST_OBF] || fifo_empty)
                begin
                    rsp_next.result_code = RES_NO_DATA;
                end
                else
                begin
                    output_byte_next    = fifo_reg[head_reg];
                    status_next[ST_OBF] = 1'b1;
                    head_next           = head_inc;
                    count_next          = count_reg - CNT_W'(1);
                    rsp_next.irq_raised = 1'b1;
                end
            end
            OP_PUSH:
            begin
                if (fifo_full)
                begin
                    rsp_next.result_code = RES_DROPPED;
                end
                else
                begin
                    fifo_write = 1'b1;
                    tail_next  = tail_inc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
        endcase

        rsp_next.a20_gate = output_port_next[A20_BIT];
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            status_reg       <= STATUS_RST;
            output_byte_reg  <= '0;
            pending_reg      <= PEND_NONE;
            command_byte_reg <= CMDBYTE_RST;
            output_port_reg  <= OUTPORT_RST;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (s1_advance)
            begin
                status_reg       <= status_next;
                output_byte_reg  <= output_byte_next;
                pending_reg      <= pending_next;
                command_byte_reg <= command_byte_next;
                output_port_reg  <= output_port_next;
                head_reg         <= head_next;
                tail_reg         <= tail_next;
                count_reg        <= count_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_req_reg <= '{opcode:      opcode,
                            port_select: port_select,
                            write_byte:  write_byte,
                            scan_code:   scan_code};
        end
        if (s1_advance)
        begin
            rsp_reg <= rsp_next;
        end
        if (s1_advance && fifo_write)
        begin
            fifo_reg[tail_reg] <= s1_req_reg.scan_code;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_data   = rsp_reg.read_data;
    assign irq_raised  = rsp_reg.irq_raised;
    assign result_code = rsp_reg.result_code;
    assign a20_gate    = rsp_reg.a20_gate;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `KBC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `KBC_ASSERT_IMPLY(a_ptr_match, clk, rst_n, fifo_empty || fifo_full, head_reg == tail_reg, "queue pointers disagree with count")
    `KBC_ASSERT_ALWAYS(a_sys_flag, clk, rst_n, status_reg[ST_SYS], "system flag lost")
    `KBC_ASSERT_IMPLY(a_irq_obf, clk, rst_n, rsp_valid_reg && rsp_reg.irq_raised, status_reg[ST_OBF] && (rsp_reg.result_code == RES_OK), "delivered scan code without output-full")
    `KBC_ASSERT_NEXT(a_hold_req, clk, rst_n, s1_valid_reg && rsp_valid_reg && rsp_stall, s1_valid_reg, "captured request lost while result stalled")

endmodule
